// File: hdl/hsm_pkg.sv
package hsm_pkg;

  localparam int VAL_W   = 16;  // width of value and point fields
  localparam int BOUND_W = 40;  // stored bound width
  localparam int REL_W   = 2;
  localparam int PTS     = 4;   // point lanes carried by an item

  typedef enum logic [1:0] {
    KIND_LOAD_COEFF = 2'd0,
    KIND_LOAD_BOUND = 2'd1,
    KIND_TEST       = 2'd2,
    KIND_PROJECT    = 2'd3
  } kind_t;

  localparam logic [REL_W-1:0] REL_LT = 2'd0;
  localparam logic [REL_W-1:0] REL_LE = 2'd1;
  localparam logic [REL_W-1:0] REL_GE = 2'd2;
  localparam logic [REL_W-1:0] REL_GT = 2'd3;

  localparam logic [1:0] CFG_COMBINE_MODE  = 2'd0;
  localparam logic [1:0] CFG_PLANES_IN_USE = 2'd1;

  localparam logic MODE_AND = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

// File: hdl/hsm_ram.sv
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/hsm_dot.sv
module hsm_dot
  import hsm_pkg::*;
#(
  parameter int VARS       = 4,
  parameter int COEFF_BITS = 16,
  parameter int SUM_W      = 35
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [VARS-1:0][COEFF_BITS-1:0]     coeffs,
  input  logic [VARS-1:0][VAL_W-1:0]          xs,
  output logic                                sum_valid,
  output logic signed [SUM_W-1:0]             sum,
  output logic                                busy
);

  localparam int PROD_W = COEFF_BITS + VAL_W;

  logic signed [PROD_W-1:0] prod_r [VARS];
  logic signed [PROD_W-1:0] prod_nxt [VARS];
  logic                     prod_v_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     sum_v_r;

  // one product per lane
  always_comb begin
    for (int v = 0; v < VARS; v++) begin
      prod_nxt[v] = $signed(coeffs[v]) * $signed(xs[v]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int v = 0; v < VARS; v++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
    end else begin
      prod_v_r <= in_valid;
      sum_v_r  <= prod_v_r;
    end
    for (int v = 0; v < VARS; v++) begin
      prod_r[v] <= prod_nxt[v];
    end
    sum_r <= sum_nxt;
  end

  assign sum_valid = sum_v_r;
  assign sum       = sum_r;
  assign busy      = prod_v_r | sum_v_r;

endmodule

// File: hdl/halfspace_set_membership.sv
// Constraint table with point test and variable projection. Each item is
// taken in one transfer and answered by exactly one result transfer. A load
// passes a load state that writes the table and a finish state that registers
// the result. A test or a projection runs one plane per cycle, for each plane
// in use (capped at PLANES), through a shared lane multiplier, adder and
// subtractor pipeline fed by the plane memories. With no plane in use, or a
// projection of a variable outside the table, nothing enters the pipeline and
// the item goes on to the finish state like a load. A result that waits for
// out_ready holds the block before it returns to in_ready. After reset a
// clearing pass zeroes coefficients and bounds and sets relations to LE while
// in_ready is low; configuration writes are taken at any time.
module halfspace_set_membership
  import hsm_pkg::*;
#(
  parameter int PLANES     = 8,
  parameter int VARS       = 4,
  parameter int COEFF_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_plane_index,
  input  logic [1:0]  in_var_index,
  input  logic signed [15:0] in_value,
  input  logic [1:0]  in_relation,
  input  logic signed [15:0] in_point_x0,
  input  logic signed [15:0] in_point_x1,
  input  logic signed [15:0] in_point_x2,
  input  logic signed [15:0] in_point_x3,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_inside_res,
  output logic        out_answer_valid,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int AW     = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int CW     = $clog2(PLANES + 1);
  localparam int SUM_W  = COEFF_BITS + VAL_W + $clog2(VARS) + 1;
  localparam int CMP_W  = ((SUM_W > BOUND_W) ? SUM_W : BOUND_W) + 1;
  localparam int BR_W   = BOUND_W + REL_W;
  localparam logic signed [32:0] COEFF_MAX = 33'((longint'(1) << (COEFF_BITS - 1)) - 1);
  localparam logic signed [32:0] COEFF_MIN = -COEFF_MAX - 33'sd1;

  // configuration registers
  logic       cfg_mode_r;
  logic [3:0] cfg_planes_r;

  // latched item
  kind_t                   kind_r;
  logic [2:0]              plane_r;
  logic [1:0]              var_r;
  logic signed [VAL_W-1:0] value_r;
  logic [REL_W-1:0]        rel_r;
  logic [PTS-1:0][VAL_W-1:0] pt_r;

  // sequencer
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic            acc_r, acc_nxt;
  logic            issue;
  logic            in_xfer;
  logic            plane_ok;
  logic [CW-1:0]   n_cap;
  logic [6:0]      pidx_ext;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_inside_r, out_inside_nxt;
  logic out_answer_r, out_answer_nxt;

  // memories
  logic [VARS-1:0]                 coeff_we;
  logic [AW-1:0]                   coeff_waddr;
  logic [COEFF_BITS-1:0]           coeff_wdata;
  logic [VARS-1:0][COEFF_BITS-1:0] coeff_rd;
  logic                            bnd_we;
  logic [AW-1:0]                   bnd_waddr;
  logic [BR_W-1:0]                 bnd_wdata;
  logic [BR_W-1:0]                 bnd_rd;
  logic [AW-1:0]                   raddr;

  // pipeline
  logic                        s1_v_r;
  logic [AW-1:0]               s1_plane_r;
  logic signed [BOUND_W-1:0]   s2_bound_r, s3_bound_r;
  logic [REL_W-1:0]            s2_rel_r, s3_rel_r, s4_rel_r;
  logic [AW-1:0]               s2_plane_r, s3_plane_r, s4_plane_r;
  logic                        s4_v_r;
  logic signed [CMP_W-1:0]     s4_diff_r;
  logic signed [CMP_W-1:0]     diff_nxt;
  logic [VARS-1:0][VAL_W-1:0]  lanes;
  logic                        dot_v;
  logic signed [SUM_W-1:0]     dot_sum;
  logic                        dot_busy;
  logic                        pipe_busy;
  logic                        verdict;
  logic signed [BOUND_W-1:0]   bound_sat;
  logic signed [32:0]          coeff_ext;
  logic [COEFF_BITS-1:0]       coeff_sat;
  logic signed [BOUND_W-1:0]   bound_load;

  // configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= MODE_AND;
      cfg_planes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COMBINE_MODE:  cfg_mode_r   <= cfg_data[0];
        CFG_PLANES_IN_USE: cfg_planes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item acceptance
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= kind_t'(in_kind);
      plane_r <= in_plane_index;
      var_r   <= in_var_index;
      value_r <= in_value;
      rel_r   <= in_relation;
      pt_r    <= {in_point_x3, in_point_x2, in_point_x1, in_point_x0};
    end
  end

  // planes in use, capped at the table size
  assign n_cap = (32'(cfg_planes_r) > PLANES) ? CW'(PLANES) : CW'(cfg_planes_r);

  // check on the plane index field
  assign plane_ok = (32'(plane_r) < PLANES);
  assign pidx_ext = {4'b0, plane_r};

  // load data: coefficient saturated to its width, bound sign-extended
  assign coeff_ext  = 33'(value_r);
  assign coeff_sat  = (coeff_ext > COEFF_MAX) ? COEFF_MAX[COEFF_BITS-1:0] :
                      (coeff_ext < COEFF_MIN) ? COEFF_MIN[COEFF_BITS-1:0] :
                      coeff_ext[COEFF_BITS-1:0];
  assign bound_load = BOUND_W'(value_r);

  assign pipe_busy = s1_v_r | dot_busy | s4_v_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    issue     = 1'b0;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_inside_nxt = out_inside_r;
    out_answer_nxt = out_answer_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(PLANES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = '0;
          acc_nxt = (cfg_mode_r == MODE_AND);
          // a projection of a variable outside the table touches no plane
          if (kind_t'(in_kind) == KIND_PROJECT && !(32'(in_var_index) < VARS)) begin
            n_nxt = '0;
          end else begin
            n_nxt = n_cap;
          end
          if (kind_t'(in_kind) == KIND_TEST || kind_t'(in_kind) == KIND_PROJECT) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_FINISH;
      end
      ST_RUN: begin
        if (cnt_r != n_r) begin
          issue   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!pipe_busy) begin
          state_nxt = ST_FINISH;
        end
        // fold in each plane verdict as it leaves the pipeline
        if (s4_v_r) begin
          acc_nxt = (cfg_mode_r == MODE_AND) ? (acc_r & verdict) : (acc_r | verdict);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = (kind_r == KIND_TEST) ? acc_r : 1'b0;
          out_answer_nxt = (kind_r == KIND_TEST);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    acc_r        <= acc_nxt;
    out_inside_r <= out_inside_nxt;
    out_answer_r <= out_answer_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_answer_valid = out_answer_r;

  // memory write port: clearing pass, loads, projection write-back
  always_comb begin
    coeff_we    = '0;
    coeff_waddr = pidx_ext[AW-1:0];
    coeff_wdata = coeff_sat;
    bnd_we      = 1'b0;
    bnd_waddr   = pidx_ext[AW-1:0];
    bnd_wdata   = {rel_r, bound_load};
    case (state_r)
      ST_CLEAR: begin
        coeff_we    = '1;
        coeff_waddr = cnt_r[AW-1:0];
        coeff_wdata = '0;
        bnd_we      = 1'b1;
        bnd_waddr   = cnt_r[AW-1:0];
        bnd_wdata   = {REL_LE, BOUND_W'(0)};
      end
      ST_LOAD: begin
        for (int v = 0; v < VARS; v++) begin
          coeff_we[v] = (kind_r == KIND_LOAD_COEFF) && plane_ok && (32'(var_r) == v);
        end
        bnd_we = (kind_r == KIND_LOAD_BOUND) && plane_ok;
      end
      ST_RUN: begin
        // projection: new bound written and the projected coefficient cleared together
        if (s4_v_r && kind_r == KIND_PROJECT) begin
          for (int v = 0; v < VARS; v++) begin
            coeff_we[v] = (32'(var_r) == v);
          end
          coeff_waddr = s4_plane_r;
          coeff_wdata = '0;
          bnd_we      = 1'b1;
          bnd_waddr   = s4_plane_r;
          bnd_wdata   = {s4_rel_r, bound_sat};
        end
      end
      default: ;
    endcase
  end

  assign raddr = cnt_r[AW-1:0];

  for (genvar g = 0; g < VARS; g++) begin : g_coeff
    hsm_ram #(
      .WIDTH(COEFF_BITS),
      .DEPTH(PLANES)
    ) u_coeff_ram (
      .clk  (clk),
      .we   (coeff_we[g]),
      .waddr(coeff_waddr),
      .wdata(coeff_wdata),
      .raddr(raddr),
      .rdata(coeff_rd[g])
    );
  end

  // bound and relation share one row
  hsm_ram #(
    .WIDTH(BR_W),
    .DEPTH(PLANES)
  ) u_bound_ram (
    .clk  (clk),
    .we   (bnd_we),
    .waddr(bnd_waddr),
    .wdata(bnd_wdata),
    .raddr(raddr),
    .rdata(bnd_rd)
  );

  // lane operands: the point for a test, the value on one lane for a projection
  always_comb begin
    for (int v = 0; v < VARS; v++) begin
      if (kind_r == KIND_TEST) begin
        lanes[v] = (v < PTS) ? pt_r[2'(v)] : '0;
      end else begin
        lanes[v] = (32'(var_r) == v) ? value_r : '0;
      end
    end
  end

  hsm_dot #(
    .VARS      (VARS),
    .COEFF_BITS(COEFF_BITS),
    .SUM_W     (SUM_W)
  ) u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_v_r),
    .coeffs   (coeff_rd),
    .xs       (lanes),
    .sum_valid(dot_v),
    .sum      (dot_sum),
    .busy     (dot_busy)
  );

  // bound minus dot product serves both the compare and the projection
  assign diff_nxt = CMP_W'(s3_bound_r) - CMP_W'(dot_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s4_v_r <= dot_v;
    end
    s1_plane_r <= raddr;
    s2_plane_r <= s1_plane_r;
    s2_bound_r <= bnd_rd[BOUND_W-1:0];
    s2_rel_r   <= bnd_rd[BR_W-1:BOUND_W];
    s3_plane_r <= s2_plane_r;
    s3_bound_r <= s2_bound_r;
    s3_rel_r   <= s2_rel_r;
    s4_plane_r <= s3_plane_r;
    s4_rel_r   <= s3_rel_r;
    s4_diff_r  <= diff_nxt;
  end

  // plane verdict from the sign of bound minus sum
  always_comb begin
    case (s4_rel_r)
      REL_LT:  verdict = (s4_diff_r > 0);
      REL_LE:  verdict = (s4_diff_r >= 0);
      REL_GE:  verdict = (s4_diff_r <= 0);
      REL_GT:  verdict = (s4_diff_r < 0);
      default: verdict = 1'b0;
    endcase
  end

  // saturate the projected bound to the stored width
  always_comb begin
    if ((&s4_diff_r[CMP_W-1:BOUND_W-1]) || !(|s4_diff_r[CMP_W-1:BOUND_W-1])) begin
      bound_sat = s4_diff_r[BOUND_W-1:0];
    end else if (s4_diff_r[CMP_W-1]) begin
      bound_sat = {1'b1, {(BOUND_W-1){1'b0}}};
    end else begin
      bound_sat = {1'b0, {(BOUND_W-1){1'b1}}};
    end
  end

endmodule
